FILE: src/tvd_pkg.sv
// shared types, codes and constants of the 8-state trellis viterbi decoder
// no dependencies; imported by every module of the block but tvd_ram
package tvd_pkg;

	localparam int RING_SLOTS     = 16;
	localparam int STATES         = 8;
	localparam int SURV_DEPTH     = RING_SLOTS * STATES;
	localparam int SURV_AW        = $clog2(SURV_DEPTH);
	localparam int RING_AW        = $clog2(RING_SLOTS);
	localparam int POINT_COUNT    = 256;
	localparam int POINT_AW       = $clog2(POINT_COUNT);
	localparam int REGION_ENTRIES = 512;
	localparam int REGION_AW      = $clog2(REGION_ENTRIES);
	localparam int BOUND_ENTRIES  = 512;
	localparam int BOUND_AW       = $clog2(BOUND_ENTRIES);

	// operation codes of an input word
	localparam logic [1:0] OP_DECODE    = 2'd0;
	localparam logic [1:0] OP_WR_POINT  = 2'd1;
	localparam logic [1:0] OP_WR_REGION = 2'd2;
	localparam logic [1:0] OP_WR_BOUND  = 2'd3;

	// configuration register indexes
	localparam logic [2:0] CFG_ROTATION  = 3'd0;
	localparam logic [2:0] CFG_GRID      = 3'd1;
	localparam logic [2:0] CFG_MASK      = 3'd2;
	localparam logic [2:0] CFG_QSHIFT    = 3'd3;
	localparam logic [2:0] CFG_TB_DEPTH  = 3'd4;

	// rotation modes
	localparam logic [1:0] ROT_QUARTER = 2'd1;
	localparam logic [1:0] ROT_HALF    = 2'd3;

	localparam logic [15:0] LEAK_COEF  = 16'h799a;
	localparam logic [15:0] BM_SCALE   = 16'h0666;
	localparam logic [16:0] CELL_ROUND = 17'h00400;

	// quadrant offsets into the bound table
	localparam logic [4:0] QOFF_PP = 5'h00;
	localparam logic [4:0] QOFF_NP = 5'h08;
	localparam logic [4:0] QOFF_NN = 5'h10;
	localparam logic [4:0] QOFF_PN = 5'h18;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REGION,
		ST_BASE,
		ST_BRANCH,
		ST_DRAIN,
		ST_ACS,
		ST_TRACE,
		ST_EMIT
	} tvd_state_t;

	typedef struct packed {
		logic [2:0]          k;
		logic [POINT_AW-1:0] p;
	} dist_tag_t;

	typedef struct packed {
		logic [2:0]  st;
		logic [15:0] sym;
	} surv_word_t;

	// differential decode, index is {previous quadrant, quadrant}
	function automatic logic [1:0] diff_decode(input logic [3:0] idx);
		logic [1:0] r;
		case (idx)
			4'd0:  r = 2'd0;
			4'd1:  r = 2'd1;
			4'd2:  r = 2'd2;
			4'd3:  r = 2'd3;
			4'd4:  r = 2'd1;
			4'd5:  r = 2'd0;
			4'd6:  r = 2'd3;
			4'd7:  r = 2'd2;
			4'd8:  r = 2'd3;
			4'd9:  r = 2'd2;
			4'd10: r = 2'd0;
			4'd11: r = 2'd1;
			4'd12: r = 2'd2;
			4'd13: r = 2'd3;
			4'd14: r = 2'd1;
			4'd15: r = 2'd0;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: src/trellis_viterbi_decoder_8_state.sv
// top level of the 8-state trellis viterbi decoder: sequencer, acs, traceback
// depends on tvd_pkg, tvd_ram, tvd_surv_mem, tvd_dist
//
// usage
//   input channel (sym_valid / sym_stall): one word per operation. table writes
//   (constellation point, region offset, bound point) give no output word. a
//   decode word gives exactly one decoded_symbol word.
//   output channel (dec_valid / dec_stall): one registered output word; while the
//   receiver stalls it holds, and the next decode runs up to its final cycle and
//   waits there for the output register to free up.
//   config channel (cfg_valid / cfg_ready): cfg_ready is always high; write only
//   while the decoder is idle.
// decode sequence
//   a decode runs the eight-point branch metric pass through the bound and point
//   tables, eight acs steps sharing one add-compare unit, and one survivor memory
//   read per traceback step. sym_stall is high throughout, so no new input word
//   is taken until the decode is done.
//   table writes are accepted back to back.
// reset
//   arst_n clears metrics, ring position and quadrant history and sets the
//   configuration to its defaults; the survivor ring reads as zero through
//   per-entry valid bits. tables are undefined until written.
module trellis_viterbi_decoder_8_state (
	input  logic               clk,
	input  logic               arst_n,
	// input words
	input  logic               sym_valid,
	output logic               sym_stall,
	input  logic [1:0]         operation,
	input  logic signed [15:0] in_phase,
	input  logic signed [15:0] quadrature,
	input  logic [8:0]         table_address,
	input  logic [8:0]         table_value,
	// output words
	output logic               dec_valid,
	input  logic               dec_stall,
	output logic signed [15:0] decoded_symbol,
	// configuration writes
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import tvd_pkg::*;

	// configuration registers
	logic [1:0]  rot_mode_q;
	logic [4:0]  grid_size_q;
	logic [15:0] sym_mask_q;
	logic [3:0]  quad_shift_q;
	logic [4:0]  tb_depth_q;

	// control state
	tvd_state_t       state_q, state_d;
	logic [RING_AW-1:0] ring_q;
	logic [1:0]       prev_quad_q;
	logic [2:0]       cnt_q;
	logic [4:0]       tb_cnt_q;
	logic [RING_AW-1:0] tb_node_q;
	logic             bnd_v_s1, pnt_v_s2, sv_v_s1;
	logic             dec_valid_q;

	// decoder datapath
	logic signed [15:0] pm_q [STATES];
	logic signed [15:0] old_q [STATES];
	logic [15:0]        bm_q [STATES];
	logic [POINT_AW-1:0] pt_q [STATES];
	logic [15:0]        saved_q [STATES];
	logic signed [15:0] i_q, q_q, ri_q, rq_q;
	logic [4:0]         qoff_q;
	logic [BOUND_AW-1:0] base_q;
	logic [2:0]         bnd_k_s1, sv_k_s1;
	dist_tag_t          tag_s2;
	logic [2:0]         min_idx_q, fin_q;
	logic signed [15:0] min_val_q;
	logic [15:0]        dec_q;

	logic accept, emit_go;

	assign sym_stall = (state_q != ST_IDLE);
	assign accept    = sym_valid && !sym_stall;
	assign cfg_ready = 1'b1;

	// ---------------------------------------------------------------- tables
	logic                 pnt_we, reg_we, bnd_we;
	logic [31:0]          pnt_rdata;
	logic [REGION_AW-1:0] reg_raddr;
	logic [8:0]           reg_rdata;
	logic [BOUND_AW-1:0]  bnd_raddr;
	logic [7:0]           bnd_rdata;

	assign pnt_we = accept && operation == OP_WR_POINT
		&& {1'b0, table_address} < 10'(POINT_COUNT);
	assign reg_we = accept && operation == OP_WR_REGION
		&& {1'b0, table_address} < 10'(REGION_ENTRIES);
	assign bnd_we = accept && operation == OP_WR_BOUND
		&& {1'b0, table_address} < 10'(BOUND_ENTRIES);

	tvd_ram #(.WIDTH(32), .DEPTH(POINT_COUNT)) u_points (
		.clk   (clk),
		.we    (pnt_we),
		.waddr (table_address[POINT_AW-1:0]),
		.wdata ({in_phase, quadrature}),
		.raddr (bnd_rdata[POINT_AW-1:0]),
		.rdata (pnt_rdata)
	);

	tvd_ram #(.WIDTH(9), .DEPTH(REGION_ENTRIES)) u_regions (
		.clk   (clk),
		.we    (reg_we),
		.waddr (table_address[REGION_AW-1:0]),
		.wdata (table_value),
		.raddr (reg_raddr),
		.rdata (reg_rdata)
	);

	tvd_ram #(.WIDTH(8), .DEPTH(BOUND_ENTRIES)) u_bounds (
		.clk   (clk),
		.we    (bnd_we),
		.waddr (table_address[BOUND_AW-1:0]),
		.wdata (table_value[7:0]),
		.raddr (bnd_raddr),
		.rdata (bnd_rdata)
	);

	// ---------------------------------------------------------------- rotation at accept
	logic signed [16:0] rot_sum, rot_dif, rot_sum_w, rot_dif_w;
	logic signed [15:0] ri_d, rq_d;

	always_comb begin
		rot_sum   = {in_phase[15], in_phase} + {quadrature[15], quadrature};
		rot_dif   = {quadrature[15], quadrature} - {in_phase[15], in_phase};
		// half rotation wraps the sum to 16 bits first
		rot_sum_w = {rot_sum[15], rot_sum[15:0]};
		rot_dif_w = {rot_dif[15], rot_dif[15:0]};
		ri_d = in_phase;
		rq_d = quadrature;
		if (rot_mode_q == ROT_QUARTER) begin
			ri_d = 16'(rot_sum >>> 2);
			rq_d = 16'(rot_dif >>> 2);
		end else if (rot_mode_q == ROT_HALF) begin
			ri_d = 16'(rot_sum_w >>> 1);
			rq_d = 16'(rot_dif_w >>> 1);
		end
	end

	// ---------------------------------------------------------------- region index
	logic [4:0]  grid, lim;
	logic [16:0] abs_i, abs_q, cell_i, cell_q;
	logic [4:0]  ci, cq;
	logic [5:0]  cq_ext;
	logic [11:0] region_idx;
	logic [4:0]  qoff_d;

	always_comb begin
		grid   = (grid_size_q == 5'd0) ? 5'd1 : grid_size_q;
		lim    = grid - 5'd1;
		abs_i  = ri_q[15] ? 17'(-{ri_q[15], ri_q}) : {1'b0, ri_q};
		abs_q  = rq_q[15] ? 17'(-{rq_q[15], rq_q}) : {1'b0, rq_q};
		cell_i = (abs_i + CELL_ROUND) >> 11;
		cell_q = (abs_q + CELL_ROUND) >> 11;
		ci     = (cell_i > 17'(lim)) ? lim : cell_i[4:0];
		cq     = (cell_q > 17'(lim)) ? lim : cell_q[4:0];
		// upper triangle of the grid maps to a second block of entries
		cq_ext = {1'b0, cq} + ((cq > ci) ? {1'b0, grid} : 6'd0);
		region_idx = 12'(ci) + 12'(grid) * 12'(cq_ext);
		reg_raddr  = region_idx[REGION_AW-1:0];
		if (!ri_q[15] && ri_q != 16'sd0) begin
			qoff_d = (!rq_q[15] && rq_q != 16'sd0) ? QOFF_PP : QOFF_PN;
		end else begin
			qoff_d = (!rq_q[15] && rq_q != 16'sd0) ? QOFF_NP : QOFF_NN;
		end
	end

	// ---------------------------------------------------------------- branch metric pass
	logic               dist_v;
	dist_tag_t          dist_tag;
	logic [15:0]        dist_bm;
	logic signed [32:0] leak_prod;

	assign bnd_raddr = base_q + BOUND_AW'(cnt_q);
	assign leak_prod = pm_q[cnt_q] * $signed({1'b0, LEAK_COEF});

	tvd_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pnt_v_s2),
		.in_tag    (tag_s2),
		.rx_i      (i_q),
		.rx_q      (q_q),
		.coord     (pnt_rdata),
		.out_valid (dist_v),
		.out_tag   (dist_tag),
		.bm        (dist_bm)
	);

	// ---------------------------------------------------------------- survivor memory
	logic                surv_we;
	logic [SURV_AW-1:0]  surv_waddr, surv_raddr;
	surv_word_t          surv_wdata, surv_rdata;

	tvd_surv_mem u_surv (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (surv_we),
		.waddr  (surv_waddr),
		.wdata  (surv_wdata),
		.raddr  (surv_raddr),
		.rdata  (surv_rdata)
	);

	// ---------------------------------------------------------------- add-compare-select
	// state s: predecessors {s[0], k}, branch x in gray order for odd states
	logic               acs_odd;
	logic [1:0]         acs_h, acs_x, best_k;
	logic signed [15:0] cand [4];
	logic signed [15:0] best_m;

	always_comb begin
		acs_odd = cnt_q[0];
		acs_h   = cnt_q[2:1];
		acs_x   = acs_odd ? {acs_h[1], acs_h[0] ^ acs_h[1]} : acs_h;
		for (int k = 0; k < 4; k++) begin
			cand[k] = old_q[{acs_odd, 2'(k)}] + $signed(bm_q[{acs_odd, 2'(k) ^ acs_x}]);
		end
		best_k = 2'd0;
		best_m = cand[0];
		for (int k = 1; k < 4; k++) begin
			if (cand[k] < best_m) begin
				best_k = 2'(k);
				best_m = cand[k];
			end
		end
		surv_we          = (state_q == ST_ACS);
		surv_waddr       = {ring_q, cnt_q};
		surv_wdata.st    = {acs_odd, best_k};
		surv_wdata.sym   = 16'(pt_q[{acs_odd, best_k ^ acs_x}]);
	end

	// ---------------------------------------------------------------- traceback
	logic [2:0] cur_best;
	logic       tb_more;

	assign cur_best = (tb_cnt_q == 5'd0) ? min_idx_q : surv_rdata.st;
	assign tb_more  = tb_cnt_q < tb_depth_q;

	always_comb begin
		if (state_q == ST_TRACE) begin
			surv_raddr = {tb_node_q, cur_best};
		end else begin
			surv_raddr = {ring_q, cnt_q};
		end
	end

	// ---------------------------------------------------------------- differential decode
	logic [15:0] sym_m, low_mask, dsh, res;
	logic [1:0]  quad, dval;

	always_comb begin
		sym_m    = saved_q[fin_q] & sym_mask_q;
		quad     = 2'((sym_m >> quad_shift_q) & 16'd3);
		dval     = diff_decode({prev_quad_q, quad});
		low_mask = ~(16'hffff << quad_shift_q);
		dsh      = 16'(dval) << quad_shift_q;
		res      = dsh + (sym_m & low_mask);
	end

	assign emit_go = (state_q == ST_EMIT) && (!dec_valid_q || !dec_stall);

	// ---------------------------------------------------------------- sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && operation == OP_DECODE) begin
					state_d = ST_REGION;
				end
			end
			ST_REGION: state_d = ST_BASE;
			ST_BASE:   state_d = ST_BRANCH;
			ST_BRANCH: begin
				if (cnt_q == 3'd7) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (dist_v && dist_tag.k == 3'd7) begin
					state_d = ST_ACS;
				end
			end
			ST_ACS: begin
				if (cnt_q == 3'd7) begin
					state_d = ST_TRACE;
				end
			end
			ST_TRACE: begin
				if (!tb_more) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_mode_q   <= 2'd0;
			grid_size_q  <= 5'd8;
			sym_mask_q   <= 16'd127;
			quad_shift_q <= 4'd5;
			tb_depth_q   <= 5'd16;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ROTATION: rot_mode_q   <= cfg_data[1:0];
				CFG_GRID:     grid_size_q  <= cfg_data[4:0];
				CFG_MASK:     sym_mask_q   <= cfg_data;
				CFG_QSHIFT:   quad_shift_q <= cfg_data[3:0];
				CFG_TB_DEPTH: tb_depth_q   <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q      <= '0;
			prev_quad_q <= 2'd0;
			cnt_q       <= 3'd0;
			tb_cnt_q    <= 5'd0;
			tb_node_q   <= '0;
			bnd_v_s1    <= 1'b0;
			pnt_v_s2    <= 1'b0;
			sv_v_s1     <= 1'b0;
			dec_valid_q <= 1'b0;
			for (int j = 0; j < STATES; j++) begin
				pm_q[j] <= 16'sd0;
			end
		end else begin
			bnd_v_s1 <= (state_q == ST_BRANCH);
			pnt_v_s2 <= bnd_v_s1;
			sv_v_s1  <= (state_q == ST_BRANCH);
			if (accept && operation == OP_DECODE) begin
				ring_q <= ring_q + RING_AW'(1);
			end
			if (state_q == ST_BRANCH || state_q == ST_ACS) begin
				cnt_q <= cnt_q + 3'd1;
			end
			if (state_q == ST_ACS) begin
				pm_q[cnt_q] <= best_m;
				if (cnt_q == 3'd7) begin
					tb_cnt_q  <= 5'd0;
					tb_node_q <= ring_q;
				end
			end
			if (state_q == ST_TRACE && tb_more) begin
				tb_cnt_q  <= tb_cnt_q + 5'd1;
				tb_node_q <= tb_node_q - RING_AW'(1);
			end
			if (emit_go) begin
				dec_valid_q <= 1'b1;
				prev_quad_q <= quad;
			end else if (!dec_stall) begin
				dec_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			i_q  <= in_phase;
			q_q  <= quadrature;
			ri_q <= ri_d;
			rq_q <= rq_d;
		end
		if (state_q == ST_REGION) begin
			qoff_q <= qoff_d;
		end
		if (state_q == ST_BASE) begin
			base_q <= reg_rdata + BOUND_AW'(qoff_q);
		end
		if (state_q == ST_BRANCH) begin
			old_q[cnt_q] <= leak_prod[30:15];
		end
		bnd_k_s1 <= cnt_q;
		sv_k_s1  <= cnt_q;
		tag_s2   <= '{k: bnd_k_s1, p: bnd_rdata[POINT_AW-1:0]};
		if (sv_v_s1) begin
			saved_q[sv_k_s1] <= surv_rdata.sym;
		end
		if (dist_v) begin
			bm_q[dist_tag.k] <= dist_bm;
			pt_q[dist_tag.k] <= dist_tag.p;
		end
		if (state_q == ST_ACS) begin
			// ascending state order, strict compare keeps the lower state on ties
			if (cnt_q == 3'd0 || best_m < min_val_q) begin
				min_idx_q <= cnt_q;
				min_val_q <= best_m;
			end
		end
		if (state_q == ST_TRACE && !tb_more) begin
			fin_q <= cur_best;
		end
		if (emit_go) begin
			dec_q <= res;
		end
	end

	assign dec_valid      = dec_valid_q;
	assign decoded_symbol = dec_q;

	// ---------------------------------------------------------------- assertions
	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |=> dec_valid)
		else $error("output word not loaded after emit");

	a_surv_write_in_acs: assert property (@(posedge clk) disable iff (!arst_n)
		surv_we |-> (state_q == ST_ACS) && sym_stall)
		else $error("survivor write outside acs");

	a_tb_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TRACE) |-> (tb_cnt_q <= tb_depth_q))
		else $error("traceback ran past its depth");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TRACE) |-> !accept)
		else $error("input word accepted during traceback");

endmodule

FILE: src/tvd_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module tvd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	assign rdata = rd_q;

endmodule

FILE: src/tvd_surv_mem.sv
// survivor ring memory with per-entry valid bits, reads zero until written
// depends on tvd_pkg
module tvd_surv_mem (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         we,
	input  logic [tvd_pkg::SURV_AW-1:0]  waddr,
	input  tvd_pkg::surv_word_t          wdata,
	input  logic [tvd_pkg::SURV_AW-1:0]  raddr,
	output tvd_pkg::surv_word_t          rdata
);
	import tvd_pkg::*;

	surv_word_t            mem_q [SURV_DEPTH];
	logic [SURV_DEPTH-1:0] valid_q;
	surv_word_t            rd_q;
	logic                  rd_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rd_ok_q <= valid_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	assign rdata = rd_ok_q ? rd_q : '0;

endmodule

FILE: src/tvd_dist.sv
// three-stage scaled squared-distance pipeline for branch metrics
// depends on tvd_pkg
module tvd_dist (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  tvd_pkg::dist_tag_t  in_tag,
	input  logic signed [15:0]  rx_i,
	input  logic signed [15:0]  rx_q,
	input  logic [31:0]         coord,
	output logic                out_valid,
	output tvd_pkg::dist_tag_t  out_tag,
	output logic [15:0]         bm
);
	import tvd_pkg::*;

	logic               v_s1, v_s2, v_s3;
	dist_tag_t          tag_s1, tag_s2, tag_s3;
	logic signed [15:0] di_s1, dq_s1;
	logic signed [31:0] sqi_s2, sqq_s2;
	logic [15:0]        bm_s3;
	logic [31:0]        sum;
	logic [31:0]        scaled;

	always_comb begin
		sum    = 32'(sqi_s2) + 32'(sqq_s2);
		scaled = 32'(sum[31:16]) * 32'(BM_SCALE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= in_tag;
		di_s1  <= rx_i - $signed(coord[31:16]);
		dq_s1  <= rx_q - $signed(coord[15:0]);
		tag_s2 <= tag_s1;
		sqi_s2 <= di_s1 * di_s1;
		sqq_s2 <= dq_s1 * dq_s1;
		tag_s3 <= tag_s2;
		bm_s3  <= scaled[27:12];
	end

	assign out_valid = v_s3;
	assign out_tag   = tag_s3;
	assign bm        = bm_s3;

endmodule

FILE: test/tb_top.sv
// self-checking testbench of the 8-state trellis viterbi decoder
// depends on tvd_pkg and trellis_viterbi_decoder_8_state; drives words, predicts, compares
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tvd_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               sym_valid;
	logic               sym_stall;
	logic [1:0]         operation;
	logic signed [15:0] in_phase;
	logic signed [15:0] quadrature;
	logic [8:0]         table_address;
	logic [8:0]         table_value;
	logic               dec_valid;
	logic               dec_stall;
	logic signed [15:0] decoded_symbol;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;

	trellis_viterbi_decoder_8_state uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.sym_valid     (sym_valid),
		.sym_stall     (sym_stall),
		.operation     (operation),
		.in_phase      (in_phase),
		.quadrature    (quadrature),
		.table_address (table_address),
		.table_value   (table_value),
		.dec_valid     (dec_valid),
		.dec_stall     (dec_stall),
		.decoded_symbol(decoded_symbol),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// differential decode map, index is previous quadrant * 4 + quadrant
	localparam logic [1:0] QUAD_MAP [16] = '{
		2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd0, 2'd3, 2'd2,
		2'd3, 2'd2, 2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd0
	};

	// shadow configuration
	logic [1:0]  rot_mode;
	logic [4:0]  grid_cells;
	logic [15:0] sym_mask;
	logic [3:0]  quad_pos;
	logic [4:0]  trace_len;

	// shadow decoder state
	logic signed [15:0] metric [8];
	logic [3:0]         ring_pos;
	logic [2:0]         surv_from [128];
	logic [15:0]        surv_point [128];
	logic [1:0]         last_quad;
	logic [31:0]        points [256];
	logic [8:0]         regions [512];
	logic [7:0]         bounds [512];

	logic [15:0] expected_symbols [$];
	int          mismatches;
	bit          quiet_phase;

	// row of the directed table; check_now marks a result typed in by hand
	typedef struct {
		logic [1:0]  op;
		int          i;
		int          q;
		int          addr;
		int          val;
		bit          check_now;
		logic [15:0] result;
	} stim_row_t;

	stim_row_t directed [24];

	typedef struct {
		int rot;
		int grid;
		int mask;
		int qpos;
		int depth;
	} setting_t;

	setting_t settings [8];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit, far above the slowest legal run
	initial begin
		#30_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic int sx16(input logic [31:0] v);
		return int'(signed'(v[15:0]));
	endfunction

	// four candidate points and their scaled squared distances
	task automatic subset_metrics(input logic [31:0] base, input int i, input int q,
		output int pt[4], output int bm[4]);
		logic [31:0] e;
		logic [31:0] c;
		int          p;
		int          di;
		int          dq;
		for (int k = 0; k < 4; k++) begin
			p = bounds[(base + k) % 512];
			c = points[p];
			di = sx16(i - sx16(c >> 16));
			dq = sx16(q - sx16(c));
			e = (32'(di * di) + 32'(dq * dq)) >> 16;
			pt[k] = p;
			bm[k] = sx16((e * 32'h666) >> 12);
		end
	endtask

	// add-compare-select into one state, ties kept by the lower predecessor
	task automatic acs_state(input int node, input int s, input int p0, input int x,
		input int old[8], input int bm[4], input int pt[4]);
		int best;
		int m;
		int d;
		best = p0;
		m = sx16(old[p0] + bm[x]);
		for (int k = 1; k <= 3; k++) begin
			d = sx16(old[p0 + k] + bm[k ^ x]);
			if (d < m) begin
				best = p0 + k;
				m = d;
			end
		end
		metric[s] = 16'(m);
		surv_from[node + s] = 3'(best);
		surv_point[node + s] = 16'(pt[(best - p0) ^ x]);
	endtask

	// one decode step of the shadow decoder, returns the output word
	task automatic trellis_decode(input int i, input int q, output logic [15:0] word);
		int          old [8];
		logic [15:0] saved [8];
		int          pt [4];
		int          bm [4];
		int          node;
		int          ri;
		int          rq;
		int          grid;
		int          ci;
		int          cq;
		int          idx;
		int          best;
		logic [31:0] base;
		logic [31:0] sym;
		logic [31:0] quad;
		logic [31:0] res;
		ring_pos = ring_pos + 4'd1;
		node = int'(ring_pos) * 8;
		for (int j = 0; j < 8; j++) begin
			old[j] = sx16((int'(metric[j]) * 32'sh799a) >>> 15);
			saved[j] = surv_point[node + j];
		end
		ri = i;
		rq = q;
		if (rot_mode == ROT_QUARTER) begin
			ri = (i + q) >>> 2;
			rq = (q - i) >>> 2;
		end else if (rot_mode == ROT_HALF) begin
			ri = sx16(i + q) >>> 1;
			rq = sx16(q - i) >>> 1;
		end
		grid = (grid_cells == 0) ? 1 : int'(grid_cells);
		ci = ((ri < 0 ? -ri : ri) + 32'h400) >> 11;
		cq = ((rq < 0 ? -rq : rq) + 32'h400) >> 11;
		if (ci > grid - 1) ci = grid - 1;
		if (cq > grid - 1) cq = grid - 1;
		idx = (ci + grid * (cq + (cq > ci ? grid : 0))) % 512;
		base = regions[idx];
		if (sx16(ri) > 0)
			base += (sx16(rq) > 0) ? QOFF_PP : QOFF_PN;
		else
			base += (sx16(rq) > 0) ? QOFF_NP : QOFF_NN;

		subset_metrics(base, i, q, pt, bm);
		acs_state(node, 0, 0, 0, old, bm, pt);
		acs_state(node, 2, 0, 1, old, bm, pt);
		acs_state(node, 4, 0, 2, old, bm, pt);
		acs_state(node, 6, 0, 3, old, bm, pt);
		subset_metrics(base + 4, i, q, pt, bm);
		acs_state(node, 1, 4, 0, old, bm, pt);
		acs_state(node, 3, 4, 1, old, bm, pt);
		acs_state(node, 5, 4, 3, old, bm, pt);
		acs_state(node, 7, 4, 2, old, bm, pt);

		best = 0;
		for (int j = 1; j < 8; j++)
			if (metric[j] < metric[best]) best = j;
		for (int j = 0; j < int'(trace_len); j++) begin
			best = surv_from[(node + best) & 127];
			node = (node - 8) & 32'h78;
		end

		sym = saved[best] & sym_mask;
		quad = (sym >> quad_pos) & 3;
		res = (32'(QUAD_MAP[(quad + last_quad * 4) & 15]) << quad_pos)
			+ (sym & ((32'd1 << quad_pos) - 1));
		last_quad = quad[1:0];
		word = res[15:0];
	endtask

	// sends one input word and updates the shadow state once it is taken
	task automatic send_word(input logic [1:0] op, input int i, input int q,
		input int addr, input int val, input bit typed, input logic [15:0] typed_res);
		logic [15:0] word;
		@(negedge clk);
		sym_valid = 1'b1;
		operation = op;
		in_phase = 16'(i);
		quadrature = 16'(q);
		table_address = 9'(addr);
		table_value = 9'(val);
		do @(posedge clk); while (sym_stall);
		case (op)
			OP_DECODE: begin
				trellis_decode(sx16(i), sx16(q), word);
				expected_symbols.push_back(typed ? typed_res : word);
			end
			OP_WR_POINT:  if (addr < 256) points[addr] = {16'(i), 16'(q)};
			OP_WR_REGION: regions[addr] = 9'(val);
			OP_WR_BOUND:  bounds[addr] = 8'(val);
			default: ;
		endcase
	endtask

	// sender idles between words: mostly none or short, now and then long
	task automatic sender_gap();
		int n;
		n = 0;
		if (!quiet_phase) begin
			if ($urandom_range(0, 49) == 0) n = $urandom_range(20, 60);
			else if ($urandom_range(0, 3) == 0) n = $urandom_range(1, 3);
		end
		if (n > 0) begin
			@(negedge clk);
			sym_valid = 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// stop sending and let every pending word come out, then let the block settle
	task automatic drain();
		@(negedge clk);
		sym_valid = 1'b0;
		while (expected_symbols.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] index, input int data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = index;
		cfg_data = 16'(data);
		do @(posedge clk); while (!cfg_ready);
		case (index)
			CFG_ROTATION: rot_mode = 2'(data);
			CFG_GRID:     grid_cells = 5'(data);
			CFG_MASK:     sym_mask = 16'(data);
			CFG_QSHIFT:   quad_pos = 4'(data);
			CFG_TB_DEPTH: trace_len = 5'(data);
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// receiver stall: mostly short bursts, a few long ones, none in quiet phases
	initial begin
		int hold;
		hold = 0;
		dec_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else if (quiet_phase) begin
				dec_stall = 1'b0;
			end else if ($urandom_range(0, 63) == 0) begin
				dec_stall = 1'b1;
				hold = $urandom_range(20, 60);
			end else begin
				dec_stall = ($urandom_range(0, 3) == 0);
			end
		end
	end

	// compare every taken output word with the oldest expectation
	initial begin
		logic [15:0] want;
		forever begin
			@(posedge clk);
			if (arst_n && dec_valid && !dec_stall) begin
				if (expected_symbols.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word %h", decoded_symbol);
				end else begin
					want = expected_symbols.pop_front();
					if (decoded_symbol !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("decoded_symbol mismatch: expected %h actual %h",
								want, decoded_symbol);
					end
				end
			end
		end
	end

	initial begin
		int         i;
		int         q;
		int         mag;
		logic [1:0] op;

		// hand-typed rows: the first decodes after reset see an all-zero ring
		directed[0]  = '{OP_DECODE,     32767,  32767,   0,   0, 1, 16'h0000};
		directed[1]  = '{OP_DECODE,    -32768, -32768,   0,   0, 1, 16'h0000};
		directed[2]  = '{OP_DECODE,     32767, -32768,   0,   0, 1, 16'h0000};
		directed[3]  = '{OP_DECODE,    -32768,  32767,   0,   0, 1, 16'h0000};
		directed[4]  = '{OP_DECODE,         0,      0,   0,   0, 1, 16'h0000};
		directed[5]  = '{OP_DECODE,         1,     -1,   0,   0, 1, 16'h0000};
		directed[6]  = '{OP_DECODE,        -1,      1,   0,   0, 1, 16'h0000};
		directed[7]  = '{OP_WR_POINT,  -32768,  32767,   0,   0, 0, 16'h0000};
		directed[8]  = '{OP_WR_POINT,   32767, -32768, 255, 511, 0, 16'h0000};
		// point writes past the table are dropped
		directed[9]  = '{OP_WR_POINT,       0,      0, 256,   0, 0, 16'h0000};
		directed[10] = '{OP_WR_POINT,      -1,     -1, 511, 511, 0, 16'h0000};
		directed[11] = '{OP_WR_REGION,      0,      0, 511, 511, 0, 16'h0000};
		directed[12] = '{OP_WR_REGION,      0,      0,   0,   0, 0, 16'h0000};
		// bound value keeps only its low eight bits
		directed[13] = '{OP_WR_BOUND,       0,      0, 511, 511, 0, 16'h0000};
		directed[14] = '{OP_WR_BOUND,       0,      0,   0,   0, 0, 16'h0000};
		directed[15] = '{OP_DECODE,      2048,  -2048,   0,   0, 1, 16'h0000};
		directed[16] = '{OP_DECODE,     -1024,   1024,   0,   0, 1, 16'h0000};
		directed[17] = '{OP_DECODE,     16384,  16383,   0,   0, 1, 16'h0000};
		directed[18] = '{OP_DECODE,      1023,   1024,   0,   0, 0, 16'h0000};
		directed[19] = '{OP_DECODE,    -32768,      0,   0,   0, 0, 16'h0000};
		directed[20] = '{OP_DECODE,         0,  32767,   0,   0, 0, 16'h0000};
		directed[21] = '{OP_DECODE,     12345, -23456,   0,   0, 0, 16'h0000};
		directed[22] = '{OP_DECODE,     -7000,  -7000,   0,   0, 0, 16'h0000};
		directed[23] = '{OP_DECODE,     30000,   -300,   0,   0, 0, 16'h0000};

		// register settings: defaults, extremes, zero and oversized grid and depth,
		// loose mask, quadrant bits at both ends
		settings[0] = '{0,  8, 16'h007f,  5, 16};
		settings[1] = '{1,  1, 16'hffff,  0,  1};
		settings[2] = '{3, 16, 16'h0000, 13,  0};
		settings[3] = '{2,  0, 16'h3fff, 15, 31};
		settings[4] = '{1, 31, 16'h00ff,  7,  8};
		settings[5] = '{3, 16, 16'hffff, 13, 16};
		settings[6] = '{$urandom_range(0, 3), $urandom_range(1, 16), $urandom_range(0, 65535),
			$urandom_range(0, 13), $urandom_range(1, 16)};
		settings[7] = '{$urandom_range(0, 3), $urandom_range(0, 31), $urandom_range(0, 65535),
			$urandom_range(0, 15), $urandom_range(0, 31)};

		arst_n = 1'b0;
		sym_valid = 1'b0;
		operation = OP_DECODE;
		in_phase = '0;
		quadrature = '0;
		table_address = '0;
		table_value = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_ROTATION;
		cfg_data = '0;
		quiet_phase = 1'b1;
		mismatches = 0;

		rot_mode = 2'd0;
		grid_cells = 5'd8;
		sym_mask = 16'd127;
		quad_pos = 4'd5;
		trace_len = 5'd16;
		ring_pos = '0;
		last_quad = '0;
		for (int j = 0; j < 8; j++) metric[j] = '0;
		for (int j = 0; j < 128; j++) begin
			surv_from[j] = '0;
			surv_point[j] = '0;
		end

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// fill every table entry so that no decode reads an unwritten one
		for (int a = 0; a < 256; a++)
			send_word(OP_WR_POINT, $urandom_range(0, 65535), $urandom_range(0, 65535),
				a, 0, 0, '0);
		for (int a = 0; a < 512; a++)
			send_word(OP_WR_REGION, 0, 0, a, $urandom_range(0, 511), 0, '0);
		for (int a = 0; a < 512; a++)
			send_word(OP_WR_BOUND, 0, 0, a, $urandom_range(0, 511), 0, '0);

		// directed rows, reset configuration
		quiet_phase = 1'b0;
		foreach (directed[r]) begin
			send_word(directed[r].op, directed[r].i, directed[r].q, directed[r].addr,
				directed[r].val, directed[r].check_now, directed[r].result);
			sender_gap();
		end
		drain();

		// random phases, each under its own register setting
		foreach (settings[p]) begin
			write_reg(CFG_ROTATION, settings[p].rot);
			write_reg(CFG_GRID, settings[p].grid);
			write_reg(CFG_MASK, settings[p].mask);
			write_reg(CFG_QSHIFT, settings[p].qpos);
			write_reg(CFG_TB_DEPTH, settings[p].depth);
			quiet_phase = (p == 2);
			for (int n = 0; n < 122; n++) begin
				op = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(1, 3)) : OP_DECODE;
				// mix of magnitudes so that all grid cells and saturation get hit
				case ($urandom_range(0, 3))
					0: mag = 65535;
					1: mag = 4095;
					2: mag = 16383;
					default: mag = 1023;
				endcase
				if (mag == 65535) begin
					i = $urandom_range(0, 65535);
					q = $urandom_range(0, 65535);
				end else begin
					i = int'($urandom_range(0, 2 * mag)) - mag;
					q = int'($urandom_range(0, 2 * mag)) - mag;
				end
				send_word(op, i, q, $urandom_range(0, 511), $urandom_range(0, 511), 0, '0);
				sender_gap();
			end
			drain();
		end

		mismatches += expected_symbols.size();
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: sim.f
src/tvd_pkg.sv
src/tvd_ram.sv
src/tvd_surv_mem.sv
src/tvd_dist.sv
src/trellis_viterbi_decoder_8_state.sv
test/tb_top.sv
